[design/cosot_pkg.sv]
// shared types and codes for the count-ordered self-organizing table
package cosot_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  // command broadcast from the sequencer to every cell
  typedef struct packed {
    logic        find;
    logic        move;
    logic        insert;
    logic [31:0] key;
    logic [31:0] hit_count;
  } cell_cmd_t;

endpackage

[design/cosot_if.sv]
// request and response channel interfaces
interface cosot_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] key;
  logic [3:0]         index;

  modport source (output valid, output opcode, output key, output index, input ready);
  modport sink (input valid, input opcode, input key, input index, output ready);
endinterface

interface cosot_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [3:0]         position;
  logic signed [31:0] entry_key;
  logic [31:0]        entry_count;

  modport source (output valid, output status, output position, output entry_key,
                  output entry_count, input ready);
  modport sink (input valid, input status, input position, input entry_key,
                input entry_count, output ready);
endinterface

[design/cosot_cell.sv]
// one table slot: key and count, match chain and shift toward the tail
module cosot_cell (
  input  logic                 clk,
  input  cosot_pkg::cell_cmd_t cmd,
  input  logic                 valid,
  input  logic                 insert_sel,
  input  logic [31:0]          left_key,
  input  logic [31:0]          left_count,
  input  logic                 left_seen,
  input  logic                 left_span,
  output logic [31:0]          key,
  output logic [31:0]          count,
  output logic                 seen,
  output logic                 span,
  output logic                 dest,
  output logic [31:0]          hit_count
);
  import cosot_pkg::*;

  logic match;
  logic first;
  logic at_hit;
  logic past;
  logic le;

  assign match     = valid && (key == cmd.key);
  assign seen      = left_seen | match;
  assign first     = match & ~left_seen;
  assign hit_count = first ? count : '0;

  // counts are non-increasing, so le is monotone along the row
  assign le   = (count <= cmd.hit_count);
  assign span = ~past & (at_hit | le);
  assign dest = span & ~left_span;

  always_ff @(posedge clk) begin
    if (cmd.find) begin
      at_hit <= first;
      past   <= left_seen;
    end
    if (cmd.insert && insert_sel) begin
      key   <= cmd.key;
      count <= '0;
    end else if (cmd.move && span) begin
      if (dest) begin
        key   <= cmd.key;
        count <= cmd.hit_count;
      end else begin
        key   <= left_key;
        count <= left_count;
      end
    end
  end

endmodule

[design/count_ordered_self_organizing_table.sv]
// top level: sequencer, row of table cells and response register
// search steps: accept, match chain, shift, response; insert and read: accept, execute, response
// one item at a time: the next item is accepted once the current response is registered
// a finished response waits in the output register while the next item is taken
// the match and shift phases ripple through the row of DEPTH cells
// synchronous reset empties the table and clears the response valid
module count_ordered_self_organizing_table #(
  parameter int DEPTH = 16
) (
  input logic        clk,
  input logic        rst,
  cosot_req_if.sink   req,
  cosot_rsp_if.source rsp
);
  import cosot_pkg::*;

  localparam int OW = $clog2(DEPTH + 1);
  localparam int CW = (OW > 4) ? OW : 4;
  localparam int RD = (DEPTH < 16) ? DEPTH : 16;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_FIND   = 5'b00100,
    S_MOVE   = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t      state;
  logic [OW-1:0] occupancy;
  opcode_t     op;
  logic [31:0] skey;
  logic [3:0]  sindex;
  logic [31:0] hit_cnt;

  status_t     res_status;
  logic [3:0]  res_position;
  logic [31:0] res_key;
  logic [31:0] res_count;

  logic        out_valid;
  status_t     out_status;
  logic [3:0]  out_position;
  logic [31:0] out_key;
  logic [31:0] out_count;

  cell_cmd_t   cmd;
  logic [31:0] cell_key [DEPTH];
  logic [31:0] cell_count [DEPTH];
  logic [31:0] cell_hit [DEPTH];
  logic [DEPTH-1:0] seen_v;
  logic [DEPTH-1:0] span_v;
  logic [DEPTH-1:0] dest_v;
  logic [DEPTH-1:0] valid_v;
  logic [DEPTH-1:0] insert_v;

  logic [31:0] hit_sum;
  logic [31:0] hit_inc;
  logic [3:0]  dest_pos;
  logic [31:0] rd_key;
  logic [31:0] rd_count;
  logic        not_full;
  logic        rd_ok;
  logic        out_free;

  assign not_full = (occupancy < OW'(DEPTH));
  assign rd_ok    = (CW'(sindex) < CW'(occupancy));
  assign out_free = !out_valid || rsp.ready;

  always_comb begin
    cmd           = '0;
    cmd.find      = (state == S_FIND);
    cmd.move      = (state == S_MOVE);
    cmd.insert    = (state == S_EXEC) && (op == OP_INSERT) && not_full;
    cmd.key       = skey;
    cmd.hit_count = hit_cnt;
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid_v[i]  = (OW'(i) < occupancy);
      insert_v[i] = (OW'(i) == occupancy);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0] lk;
    logic [31:0] lc;
    logic        ls;
    logic        lsp;
    if (i == 0) begin : g_head
      assign lk  = '0;
      assign lc  = '0;
      assign ls  = 1'b0;
      assign lsp = 1'b0;
    end else begin : g_body
      assign lk  = cell_key[i-1];
      assign lc  = cell_count[i-1];
      assign ls  = seen_v[i-1];
      assign lsp = span_v[i-1];
    end
    cosot_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .valid      (valid_v[i]),
      .insert_sel (insert_v[i]),
      .left_key   (lk),
      .left_count (lc),
      .left_seen  (ls),
      .left_span  (lsp),
      .key        (cell_key[i]),
      .count      (cell_count[i]),
      .seen       (seen_v[i]),
      .span       (span_v[i]),
      .dest       (dest_v[i]),
      .hit_count  (cell_hit[i])
    );
  end

  // only the first matching cell drives a nonzero count
  always_comb begin
    hit_sum  = '0;
    dest_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_sum  = hit_sum | cell_hit[i];
      dest_pos = dest_pos | (dest_v[i] ? 4'(i) : 4'd0);
    end
    hit_inc = (hit_sum == COUNT_MAX) ? hit_sum : hit_sum + 32'd1;
  end

  always_comb begin
    rd_key   = '0;
    rd_count = '0;
    for (int i = 0; i < RD; i++) begin
      if (sindex == 4'(i)) begin
        rd_key   = cell_key[i];
        rd_count = cell_count[i];
      end
    end
  end

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occupancy <= '0;
      out_valid <= 1'b0;
    end else begin
      // a response leaving while the next one loads is handled in S_RESULT
      if (out_valid && rsp.ready && state != S_RESULT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op     <= opcode_t'(req.opcode);
            skey   <= req.key;
            sindex <= req.index;
            unique case (opcode_t'(req.opcode))
              OP_SEARCH: state <= S_FIND;
              OP_INSERT: state <= S_EXEC;
              OP_READ:   state <= S_EXEC;
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_EXEC: begin
          if (op == OP_INSERT) begin
            if (not_full) begin
              occupancy    <= occupancy + OW'(1);
              res_status   <= ST_OK;
              res_position <= 4'(occupancy);
              res_key      <= skey;
              res_count    <= '0;
            end else begin
              res_status   <= ST_FULL;
              res_position <= '0;
              res_key      <= '0;
              res_count    <= '0;
            end
          end else begin
            res_position <= sindex;
            if (rd_ok) begin
              res_status <= ST_OK;
              res_key    <= rd_key;
              res_count  <= rd_count;
            end else begin
              res_status <= ST_RANGE;
              res_key    <= '0;
              res_count  <= '0;
            end
          end
          state <= S_RESULT;
        end
        S_FIND: begin
          if (seen_v[DEPTH-1]) begin
            hit_cnt <= hit_inc;
            state   <= S_MOVE;
          end else begin
            res_status   <= ST_MISS;
            res_position <= '0;
            res_key      <= '0;
            res_count    <= '0;
            state        <= S_RESULT;
          end
        end
        S_MOVE: begin
          res_status   <= ST_OK;
          res_position <= dest_pos;
          res_key      <= skey;
          res_count    <= hit_cnt;
          state        <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            out_status   <= res_status;
            out_position <= res_position;
            out_key      <= res_key;
            out_count    <= res_count;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.position    = out_position;
  assign rsp.entry_key   = out_key;
  assign rsp.entry_count = out_count;

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OW'(DEPTH))
    else $error("occupancy above table depth");

  a_one_dest: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE) |-> $onehot(dest_v))
    else $error("shift without exactly one destination cell");

  a_occ_only_exec: assert property (@(posedge clk) disable iff (rst)
    (state != S_EXEC) |=> $stable(occupancy))
    else $error("occupancy changed outside insert");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.opcode != OP_NONE) |=> !req.ready)
    else $error("accepted item did not start work");

endmodule

[dv/tb_count_ordered_self_organizing_table.sv]
// testbench for the count-ordered self-organizing table: predicted responses checked per item
`timescale 1ns / 100ps

module tb_count_ordered_self_organizing_table;
  import cosot_pkg::*;

  localparam int DEPTH = 16;

  typedef struct {
    status_t     status;
    logic [3:0]  position;
    logic [31:0] entry_key;
    logic [31:0] entry_count;
  } table_rsp_t;

  logic clk;
  logic rst;

  cosot_req_if req_ch ();
  cosot_rsp_if rsp_ch ();

  count_ordered_self_organizing_table #(.DEPTH(DEPTH)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // predicted table contents
  logic [31:0] tbl_key [DEPTH];
  logic [31:0] tbl_cnt [DEPTH];
  int          fill;

  table_rsp_t  pending_rsp [$];
  int          err_count;
  bit          idle_on;
  int          hold_cycles;

  logic [31:0] key_pool [8] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                                32'h0000_0001, 32'hAAAA_5555, 32'h5555_AAAA, 32'h0000_0042};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic apply_table_op(input opcode_t op, input logic [31:0] k, input logic [3:0] ix,
                                output bit has_rsp, output table_rsp_t r);
    int          q;
    int          hit;
    int          dest;
    bit          found;
    logic [31:0] cnt;
    has_rsp       = 1'b1;
    r.status      = ST_OK;
    r.position    = '0;
    r.entry_key   = '0;
    r.entry_count = '0;
    case (op)
      OP_INSERT: begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          tbl_key[fill] = k;
          tbl_cnt[fill] = '0;
          r.position    = fill[3:0];
          r.entry_key   = k;
          fill++;
        end
      end
      OP_SEARCH: begin
        found = 1'b0;
        hit   = 0;
        for (q = 0; q < fill; q++) begin
          if (!found && tbl_key[q] == k) begin
            hit   = q;
            found = 1'b1;
          end
        end
        if (!found) begin
          r.status = ST_MISS;
        end else begin
          cnt = tbl_cnt[hit];
          if (cnt != COUNT_MAX) cnt++;
          // first earlier entry whose count is not greater
          dest  = hit;
          found = 1'b0;
          for (q = 0; q < hit; q++) begin
            if (!found && tbl_cnt[q] <= cnt) begin
              dest  = q;
              found = 1'b1;
            end
          end
          for (q = hit; q > dest; q--) begin
            tbl_key[q] = tbl_key[q-1];
            tbl_cnt[q] = tbl_cnt[q-1];
          end
          tbl_key[dest] = k;
          tbl_cnt[dest] = cnt;
          r.position    = dest[3:0];
          r.entry_key   = k;
          r.entry_count = cnt;
        end
      end
      OP_READ: begin
        r.position = ix;
        if (ix >= fill) begin
          r.status = ST_RANGE;
        end else begin
          r.entry_key   = tbl_key[ix];
          r.entry_count = tbl_cnt[ix];
        end
      end
      default: has_rsp = 1'b0;
    endcase
  endtask

  // offer one item, wait for acceptance, then maybe idle
  task automatic send_item(input opcode_t op, input logic [31:0] k, input logic [3:0] ix);
    bit         has_rsp;
    table_rsp_t r;
    req_ch.valid  <= 1'b1;
    req_ch.opcode <= op;
    req_ch.key    <= k;
    req_ch.index  <= ix;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    apply_table_op(op, k, ix, has_rsp, r);
    if (has_rsp) pending_rsp.push_back(r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // response sink with random stalls and an occasional long hold-off
  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : rsp_check
    table_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected response: status %0d position %0d", rsp_ch.status, rsp_ch.position);
        err_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
          err_count++;
        end
        if (rsp_ch.position !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, rsp_ch.position);
          err_count++;
        end
        if (rsp_ch.entry_key !== want.entry_key) begin
          $error("entry_key: expected %h, actual %h", want.entry_key, rsp_ch.entry_key);
          err_count++;
        end
        if (rsp_ch.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", want.entry_count, rsp_ch.entry_count);
          err_count++;
        end
      end
    end
  end

  task automatic test_empty_table();
    send_item(OP_READ, 32'h0, 4'd0);
    send_item(OP_READ, $urandom, 4'd15);
    send_item(OP_SEARCH, 32'h0000_1234, 4'd0);
    send_item(OP_NONE, 32'hFFFF_FFFF, 4'hF);
  endtask

  task automatic test_insert_extremes();
    send_item(OP_INSERT, 32'h8000_0000, 4'd0);
    send_item(OP_INSERT, 32'h7FFF_FFFF, 4'hF);
    send_item(OP_INSERT, 32'h0000_0000, 4'd0);
    send_item(OP_INSERT, 32'hFFFF_FFFF, 4'd0);
    // duplicate key, a search should only touch the first one
    send_item(OP_INSERT, 32'h8000_0000, 4'd0);
  endtask

  task automatic test_search_reorder();
    send_item(OP_SEARCH, 32'h0000_0000, 4'd0);
    // equal count ahead: entry still moves in front of it
    send_item(OP_SEARCH, 32'h8000_0000, 4'd0);
    send_item(OP_SEARCH, 32'hFFFF_FFFF, 4'd0);
    send_item(OP_SEARCH, 32'h0000_0055, 4'd0);
  endtask

  task automatic test_read_entries();
    int i;
    for (i = 0; i < 6; i++) send_item(OP_READ, $urandom, i[3:0]);
    send_item(OP_READ, $urandom, 4'd15);
  endtask

  task automatic send_random_item();
    int          pick;
    logic [31:0] k;
    opcode_t     op;
    pick = $urandom_range(0, 99);
    k    = ($urandom_range(0, 1) == 0) ? key_pool[$urandom_range(0, 7)] : $urandom;
    if (pick < ((fill < DEPTH) ? 15 : 5)) begin
      op = OP_INSERT;
    end else if (pick < 70) begin
      op = OP_SEARCH;
      // mostly hits on keys known to be in the table
      if (fill > 0 && $urandom_range(0, 4) != 0) k = tbl_key[$urandom_range(0, fill - 1)];
    end else if (pick < 95) begin
      op = OP_READ;
    end else begin
      op = OP_NONE;
    end
    send_item(op, k, 4'($urandom_range(0, 15)));
  endtask

  task automatic test_random_traffic(input int n);
    repeat (n) send_random_item();
  endtask

  task automatic test_backpressure(input int n);
    hold_cycles = 120;
    repeat (n) send_random_item();
  endtask

  task automatic test_no_idle_tail(input int n);
    idle_on = 1'b0;
    repeat (n) send_random_item();
  endtask

  initial begin
    int waited;
    err_count     = 0;
    fill          = 0;
    idle_on       = 1'b1;
    hold_cycles   = 0;
    rst          <= 1'b1;
    req_ch.valid  <= 1'b0;
    req_ch.opcode <= OP_NONE;
    req_ch.key    <= '0;
    req_ch.index  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_insert_extremes();
    test_search_reorder();
    test_read_entries();
    test_random_traffic(420);
    test_backpressure(20);
    test_no_idle_tail(60);

    req_ch.valid <= 1'b0;
    waited = 0;
    while (pending_rsp.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_rsp.size() != 0) begin
      $error("%0d responses never arrived", pending_rsp.size());
      err_count++;
    end
    repeat (10) @(posedge clk);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
